>>> sv/slsc_pkg.sv
`timescale 1ns / 1ps
package slsc_pkg;

  localparam int TabLen = 24;

  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam logic [30:0] LA_MAX    = 31'h7FFF_FFFF;
  localparam logic [29:0] KINV_Q30  = 30'd652032874;

  // register indexes of the configuration port
  localparam logic REG_WHEELBASE  = 1'b0;
  localparam logic REG_SPEED_GAIN = 1'b1;

  localparam logic [15:0] WHEELBASE_RST  = 16'd768;
  localparam logic [15:0] SPEED_GAIN_RST = 16'd256;

  typedef logic [31:0] atan_tab_t [TabLen];

  // arctan(2^-i) in turns, 2^32 = one turn
  localparam atan_tab_t ATAN_TURNS = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // table entry rounded to the angle grid
  function automatic logic [31:0] atan_entry(input int idx, input int angle_bits);
    logic [31:0] half;
    logic [31:0] mask;
    half = 32'd1 << (31 - angle_bits);
    mask = ~((32'd1 << (32 - angle_bits)) - 32'd1);
    return (ATAN_TURNS[idx] + half) & mask;
  endfunction

endpackage

>>> sv/slsc_in_if.sv
`timescale 1ns / 1ps
interface slsc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] heading;
  logic        [15:0] speed;
  logic signed [31:0] goal_x;
  logic signed [31:0] goal_y;
  logic signed [15:0] goal_heading;

  modport source (
    output valid, pos_x, pos_y, heading, speed, goal_x, goal_y, goal_heading,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, heading, speed, goal_x, goal_y, goal_heading,
    output ready
  );
endinterface

>>> sv/slsc_out_if.sv
`timescale 1ns / 1ps
interface slsc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] steer_angle;

  modport source (output valid, steer_angle, input ready);
  modport sink (input valid, steer_angle, output ready);
endinterface

>>> sv/stanley_lookahead_steering_core.sv
`timescale 1ns / 1ps
// Stanley lateral steering with lookahead. Each pose transfer (rear axle position, heading,
// speed and the matched trajectory point) yields one steering angle, in order. The block is
// a single pipeline that takes a new pose every cycle unless it is stalled. The two
// sine/cosine rotators run beside the 2-bit-per-stage lookahead divider, followed by
// the multiply/add stages and the atan2 vectoring rotator. The whole pipeline holds while
// the output register is full and not taken, so ready is low only in that case.
// wheelbase and speed_gain are to be written through the configuration port only while no
// pose is in flight; the block itself does not enforce this. A zero gain gives the saturated
// lookahead distance.
module stanley_lookahead_steering_core #(
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  slsc_in_if.sink     pose_i,
  slsc_out_if.source  steer_o
);
  import slsc_pkg::*;

  localparam int Steps       = (CORDIC_STEPS > TabLen) ? TabLen : CORDIC_STEPS;
  localparam int DivStages   = 16;
  localparam int FrontStages = (Steps > DivStages) ? Steps : DivStages;
  localparam int CW          = 34;
  localparam int DW          = 35;
  localparam int VW          = 38;
  localparam logic [31:0] GRID_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

  typedef struct packed {
    logic                 flip_h;
    logic                 flip_g;
    logic signed [CW-1:0] hx;
    logic signed [CW-1:0] hy;
    logic signed [CW-1:0] hz;
    logic signed [CW-1:0] gcx;
    logic signed [CW-1:0] gcy;
    logic signed [CW-1:0] gcz;
    logic [15:0]          rem;
    logic [31:0]          quo;
    logic [15:0]          spd;
    logic signed [31:0]   px;
    logic signed [31:0]   py;
    logic signed [31:0]   tx;
    logic signed [31:0]   ty;
    logic [31:0]          hd;
  } front_t;

  typedef struct packed {
    logic signed [CW-1:0] ch;
    logic signed [CW-1:0] sh;
    logic signed [CW-1:0] cg;
    logic signed [CW-1:0] sg;
    logic [30:0]          la_dist;
    logic signed [31:0]   px;
    logic signed [31:0]   py;
    logic signed [31:0]   tx;
    logic signed [31:0]   ty;
    logic [31:0]          hd;
  } m1_t;

  typedef struct packed {
    logic signed [CW+16:0] phx;
    logic signed [CW+16:0] phy;
    logic signed [CW+31:0] pgx;
    logic signed [CW+31:0] pgy;
    logic signed [31:0]    px;
    logic signed [31:0]    py;
    logic signed [31:0]    tx;
    logic signed [31:0]    ty;
    logic [31:0]           hd;
  } m2_t;

  typedef struct packed {
    logic signed [DW-1:0] fx;
    logic signed [DW-1:0] fy;
    logic signed [DW-1:0] lx;
    logic signed [DW-1:0] ly;
    logic [31:0]          hd;
  } m3_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic [31:0]          z;
    logic                 zero;
    logic [31:0]          hd;
  } vec_t;

  // turn left-half-plane angles by pi, returns {flip, z}
  function automatic logic [CW:0] prerot(input logic [31:0] a);
    logic        f;
    logic [31:0] r;
    f = a[31] ^ a[30];
    r = f ? (a - HALF_TURN) : a;
    return {f, {{(CW-32){r[31]}}, r}};
  endfunction

  logic [15:0] wb_q;
  logic [15:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q   <= WHEELBASE_RST;
      gain_q <= SPEED_GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_WHEELBASE:  wb_q   <= cfg_wdata_i;
        REG_SPEED_GAIN: gain_q <= cfg_wdata_i;
        default:        wb_q   <= wb_q;
      endcase
    end
  end

  logic adv;
  logic out_v_q;
  logic [15:0] out_q;

  assign adv          = !out_v_q || steer_o.ready;
  assign pose_i.ready = adv;

  // input register
  front_t fr_d0;
  front_t fr_q  [0:FrontStages];
  front_t fr_d  [1:FrontStages];
  logic   fv_q  [0:FrontStages];

  always_comb begin
    logic [31:0] hd_in;
    logic [31:0] gh_in;
    logic [CW:0] rh;
    logic [CW:0] rg;
    hd_in = {pose_i.heading, 16'h0000} & GRID_MASK;
    gh_in = {pose_i.goal_heading, 16'h0000} & GRID_MASK;
    rh    = prerot(hd_in);
    rg    = prerot(gh_in);
    fr_d0.flip_h = rh[CW];
    fr_d0.hz     = rh[CW-1:0];
    fr_d0.flip_g = rg[CW];
    fr_d0.gcz    = rg[CW-1:0];
    fr_d0.hx     = CW'(KINV_Q30);
    fr_d0.hy     = '0;
    fr_d0.gcx    = CW'(KINV_Q30);
    fr_d0.gcy    = '0;
    fr_d0.rem    = '0;
    fr_d0.quo    = '0;
    fr_d0.spd    = pose_i.speed;
    fr_d0.px     = pose_i.pos_x;
    fr_d0.py     = pose_i.pos_y;
    fr_d0.tx     = pose_i.goal_x;
    fr_d0.ty     = pose_i.goal_y;
    fr_d0.hd     = hd_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q[0] <= 1'b0;
    end else if (adv) begin
      fv_q[0] <= pose_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fr_q[0] <= fr_d0;
    end
  end

  // sine/cosine rotators for both angles beside the restoring divider
  for (genvar k = 0; k < FrontStages; k++) begin : g_front
    localparam logic signed [CW-1:0] Atan = CW'(atan_entry(k, ANGLE_BITS));

    always_comb begin
      front_t      f;
      logic [31:0] num;
      logic [16:0] trial;
      logic        qb;
      f   = fr_q[k];
      num = {fr_q[k].spd, 16'h0000};
      if (k < Steps) begin
        if (!fr_q[k].hz[CW-1]) begin
          f.hx = fr_q[k].hx - (fr_q[k].hy >>> k);
          f.hy = fr_q[k].hy + (fr_q[k].hx >>> k);
          f.hz = fr_q[k].hz - Atan;
        end else begin
          f.hx = fr_q[k].hx + (fr_q[k].hy >>> k);
          f.hy = fr_q[k].hy - (fr_q[k].hx >>> k);
          f.hz = fr_q[k].hz + Atan;
        end
        if (!fr_q[k].gcz[CW-1]) begin
          f.gcx = fr_q[k].gcx - (fr_q[k].gcy >>> k);
          f.gcy = fr_q[k].gcy + (fr_q[k].gcx >>> k);
          f.gcz = fr_q[k].gcz - Atan;
        end else begin
          f.gcx = fr_q[k].gcx + (fr_q[k].gcy >>> k);
          f.gcy = fr_q[k].gcy - (fr_q[k].gcx >>> k);
          f.gcz = fr_q[k].gcz + Atan;
        end
      end
      if (k < DivStages) begin
        for (int b = 0; b < 2; b++) begin
          trial = {f.rem, num[31 - 2*k - b]};
          qb    = (trial >= {1'b0, gain_q});
          f.rem = qb ? 16'(trial - {1'b0, gain_q}) : trial[15:0];
          f.quo = {f.quo[30:0], qb};
        end
      end
      fr_d[k+1] = f;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        fv_q[k+1] <= 1'b0;
      end else if (adv) begin
        fv_q[k+1] <= fv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        fr_q[k+1] <= fr_d[k+1];
      end
    end
  end

  // undo the half turn, saturate the lookahead distance
  m1_t  m1_d, m1_q;
  logic m1v_q;

  always_comb begin
    front_t f;
    f            = fr_q[FrontStages];
    m1_d.ch      = f.flip_h ? -f.hx : f.hx;
    m1_d.sh      = f.flip_h ? -f.hy : f.hy;
    m1_d.cg      = f.flip_g ? -f.gcx : f.gcx;
    m1_d.sg      = f.flip_g ? -f.gcy : f.gcy;
    m1_d.la_dist = f.quo[31] ? LA_MAX : f.quo[30:0];
    m1_d.px      = f.px;
    m1_d.py      = f.py;
    m1_d.tx      = f.tx;
    m1_d.ty      = f.ty;
    m1_d.hd      = f.hd;
  end

  // products
  m2_t  m2_d, m2_q;
  logic m2v_q;

  always_comb begin
    m2_d.phx = $signed({1'b0, wb_q}) * m1_q.ch;
    m2_d.phy = $signed({1'b0, wb_q}) * m1_q.sh;
    m2_d.pgx = $signed({1'b0, m1_q.la_dist}) * m1_q.cg;
    m2_d.pgy = $signed({1'b0, m1_q.la_dist}) * m1_q.sg;
    m2_d.px  = m1_q.px;
    m2_d.py  = m1_q.py;
    m2_d.tx  = m1_q.tx;
    m2_d.ty  = m1_q.ty;
    m2_d.hd  = m1_q.hd;
  end

  // front axle and lookahead point
  m3_t  m3_d, m3_q;
  logic m3v_q;

  always_comb begin
    m3_d.fx = DW'(m2_q.px) + DW'(m2_q.phx >>> 22);
    m3_d.fy = DW'(m2_q.py) + DW'(m2_q.phy >>> 22);
    m3_d.lx = DW'(m2_q.tx) + DW'(m2_q.pgx >>> 30);
    m3_d.ly = DW'(m2_q.ty) + DW'(m2_q.pgy >>> 30);
    m3_d.hd = m2_q.hd;
  end

  // difference vector into the right half plane
  vec_t vs_d0;
  vec_t vs_q [0:Steps];
  vec_t vs_d [1:Steps];
  logic vv_q [0:Steps];

  always_comb begin
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic                 neg;
    dx         = m3_q.lx - m3_q.fx;
    dy         = m3_q.ly - m3_q.fy;
    neg        = dx[DW-1];
    vs_d0.zero = (dx == '0) && (dy == '0);
    vs_d0.x    = neg ? -VW'(dx) : VW'(dx);
    vs_d0.y    = neg ? -VW'(dy) : VW'(dy);
    vs_d0.z    = neg ? HALF_TURN : 32'h0;
    vs_d0.hd   = m3_q.hd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1v_q   <= 1'b0;
      m2v_q   <= 1'b0;
      m3v_q   <= 1'b0;
      vv_q[0] <= 1'b0;
    end else if (adv) begin
      m1v_q   <= fv_q[FrontStages];
      m2v_q   <= m1v_q;
      m3v_q   <= m2v_q;
      vv_q[0] <= m3v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_q    <= m1_d;
      m2_q    <= m2_d;
      m3_q    <= m3_d;
      vs_q[0] <= vs_d0;
    end
  end

  // atan2 vectoring rotator
  for (genvar k = 0; k < Steps; k++) begin : g_vec
    localparam logic [31:0] Atan = atan_entry(k, ANGLE_BITS);

    always_comb begin
      vec_t v;
      v = vs_q[k];
      if (vs_q[k].y > 0) begin
        v.x = vs_q[k].x + (vs_q[k].y >>> k);
        v.y = vs_q[k].y - (vs_q[k].x >>> k);
        v.z = vs_q[k].z + Atan;
      end else begin
        v.x = vs_q[k].x - (vs_q[k].y >>> k);
        v.y = vs_q[k].y + (vs_q[k].x >>> k);
        v.z = vs_q[k].z - Atan;
      end
      vs_d[k+1] = v;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vv_q[k+1] <= 1'b0;
      end else if (adv) begin
        vv_q[k+1] <= vv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        vs_q[k+1] <= vs_d[k+1];
      end
    end
  end

  // output register, bearing minus heading wraps modulo one turn
  logic [31:0] steer;
  assign steer = (vs_q[Steps].zero ? 32'h0 : vs_q[Steps].z) - vs_q[Steps].hd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= vv_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= steer[31:16];
    end
  end

  assign steer_o.valid       = out_v_q;
  assign steer_o.steer_angle = out_q;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_v_q |-> pose_i.ready)
    else $error("pipeline stalled with empty output register");

  a_vec_right_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vv_q[0] |-> !vs_q[0].x[VW-1])
    else $error("vectoring start not in right half plane");

  a_zero_gain_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m1v_q && gain_q == 16'h0) |-> (m1_q.la_dist == LA_MAX))
    else $error("zero gain did not saturate lookahead");

endmodule

>>> dv/stanley_lookahead_steering_core_test.sv
`timescale 1ns / 1ps
module stanley_lookahead_steering_core_test;
  import slsc_pkg::*;

  localparam int  Steps     = 16;
  localparam int  CycleCap  = 500000;
  localparam int  DrainWait = 45;
  localparam int  PhaseLen  = 380;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic        [15:0] speed;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [15:0] goal_heading;
  } pose_t;

  typedef struct packed {
    pose_t       p;
    logic        typed;
    logic [15:0] angle;
  } pose_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [0:0] cfg_addr_i;
  logic [15:0] cfg_wdata_i;

  slsc_in_if  pose();
  slsc_out_if steer();

  stanley_lookahead_steering_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pose_i     (pose),
    .steer_o    (steer)
  );

  logic [15:0] wheelbase_q;
  logic [15:0] gain_q;
  logic [15:0] angle_q[$];
  logic        cur_typed;
  logic [15:0] cur_angle;
  int          mismatches;
  int          cycles;
  bit          snd_burst;
  bit          rcv_burst;
  bit          hold_req;
  pose_row_t   dir_rows[14];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // arctan step rounded to the 16-bit angle grid
  function automatic longint grid_atan(input int i);
    logic [31:0] v;
    v = (ATAN_TURNS[i] + 32'h0000_8000) & 32'hFFFF_0000;
    return longint'({32'd0, v});
  endfunction

  function automatic void rotate_unit(input logic [31:0] ang, output longint c,
                                      output longint s);
    logic [31:0] a;
    longint x, y, z, nx, ny;
    bit flip;
    a = ang;
    flip = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
    if (flip) a = a - HALF_TURN;
    z = longint'($signed(a));
    x = longint'({34'd0, KINV_Q30});
    y = 0;
    for (int i = 0; i < Steps; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z = z - grid_atan(i);
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z = z + grid_atan(i);
      end
      x = nx;
      y = ny;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [31:0] bearing_of(input longint dy, input longint dx);
    longint x, y, nx, ny;
    logic [31:0] z;
    if (dx == 0 && dy == 0) return 32'd0;
    x = dx;
    y = dy;
    z = 32'd0;
    if (dx < 0) begin
      x = -dx;
      y = -dy;
      z = HALF_TURN;
    end
    for (int i = 0; i < Steps; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z = z + 32'(grid_atan(i));
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z = z - 32'(grid_atan(i));
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  function automatic logic [15:0] steer_for(input pose_t p);
    logic [31:0] hd, gh, steer;
    longint ch, sh, cg, sg, fx, fy, lx, ly, la_dist;
    logic [63:0] q;
    hd = {p.heading, 16'h0000};
    gh = {p.goal_heading, 16'h0000};
    rotate_unit(hd, ch, sh);
    fx = longint'(p.pos_x) + ((longint'({48'd0, wheelbase_q}) * ch) >>> 22);
    fy = longint'(p.pos_y) + ((longint'({48'd0, wheelbase_q}) * sh) >>> 22);
    if (gain_q == 16'd0) begin
      la_dist = longint'({33'd0, LA_MAX});
    end else begin
      q = ({48'd0, p.speed} << 16) / {48'd0, gain_q};
      la_dist = (q > {33'd0, LA_MAX}) ? longint'({33'd0, LA_MAX}) : longint'(q);
    end
    rotate_unit(gh, cg, sg);
    lx = longint'(p.goal_x) + ((la_dist * cg) >>> 30);
    ly = longint'(p.goal_y) + ((la_dist * sg) >>> 30);
    steer = bearing_of(ly - fy, lx - fx) - hd;
    return steer[31:16];
  endfunction

  // expectation is taken when the pose transfer happens
  always @(posedge clk_i) begin
    if (rst_ni && pose.valid && pose.ready) begin
      if (cur_typed) angle_q.push_back(cur_angle);
      else angle_q.push_back(steer_for(pose_t'({pose.pos_x, pose.pos_y, pose.heading,
          pose.speed, pose.goal_x, pose.goal_y, pose.goal_heading})));
    end
  end

  always @(posedge clk_i) begin
    logic [15:0] want;
    if (rst_ni && steer.valid && steer.ready) begin
      if (angle_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected steer_angle %h", steer.steer_angle);
      end else begin
        want = angle_q.pop_front();
        if (steer.steer_angle !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("steer_angle mismatch: expected %h actual %h", want,
                     steer.steer_angle);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleCap) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off
  initial begin
    int gap;
    steer.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = rcv_burst ? 0 : $urandom_range(0, 16);
      if (hold_req) begin
        steer.ready = 1'b0;
        repeat (300) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if (gap > 0) begin
        steer.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      steer.ready = 1'b1;
      do @(posedge clk_i); while (!steer.valid);
    end
  end

  task automatic send_pose(input pose_t p, input logic typed, input logic [15:0] angle);
    int gap;
    gap = snd_burst ? 0 : $urandom_range(0, 16);
    @(negedge clk_i);
    if (gap > 0) begin
      pose.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    {pose.pos_x, pose.pos_y, pose.heading, pose.speed, pose.goal_x, pose.goal_y,
     pose.goal_heading} = p;
    cur_typed = typed;
    cur_angle = angle;
    pose.valid = 1'b1;
    do @(posedge clk_i); while (!pose.ready);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    pose.valid = 1'b0;
    while (angle_q.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_addr_i = idx;
    cfg_wdata_i = val;
    if (idx == REG_WHEELBASE) wheelbase_q = val;
    else gain_q = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic pose_t random_pose();
    pose_t p;
    p.pos_x = $urandom;
    p.pos_y = $urandom;
    p.heading = 16'($urandom);
    p.goal_heading = 16'($urandom);
    p.speed = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2560));
    if ($urandom_range(0, 3) != 0) begin
      // goal near the vehicle, as after a nearest-point match
      p.goal_x = p.pos_x + 32'($urandom_range(0, 32'h40_0000)) - 32'h20_0000;
      p.goal_y = p.pos_y + 32'($urandom_range(0, 32'h40_0000)) - 32'h20_0000;
    end else begin
      p.goal_x = $urandom;
      p.goal_y = $urandom;
    end
    return p;
  endfunction

  initial begin
    logic [15:0] wb_set[5];
    logic [15:0] gain_set[5];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = REG_WHEELBASE;
    cfg_wdata_i = 16'd0;
    pose.valid = 1'b0;
    {pose.pos_x, pose.pos_y, pose.heading, pose.speed, pose.goal_x, pose.goal_y,
     pose.goal_heading} = '0;
    cur_typed = 1'b0;
    cur_angle = 16'd0;
    mismatches = 0;
    cycles = 0;
    snd_burst = 1'b0;
    rcv_burst = 1'b0;
    hold_req = 1'b0;
    wheelbase_q = WHEELBASE_RST;
    gain_q = SPEED_GAIN_RST;

    // coincident points give a zero bearing, so steer is minus the heading
    dir_rows[0]  = '{'{32'sd123456, -32'sd7890, 16'sd0, 16'd0, 32'sd123456, -32'sd7890,
                      16'sd0}, 1'b1, 16'h0000};
    dir_rows[1]  = '{'{32'sd123456, -32'sd7890, 16'sh4000, 16'd0, 32'sd123456, -32'sd7890,
                      16'sd77}, 1'b1, 16'hC000};
    dir_rows[2]  = '{'{-32'sd5, 32'sd9, 16'sh8000, 16'd0, -32'sd5, 32'sd9, 16'sd0},
                     1'b1, 16'h8000};
    dir_rows[3]  = '{'{32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'sd0, 16'd0, 32'sh80000000,
                      32'sh80000000, 16'sd0}, 1'b0, 16'h0};
    dir_rows[4]  = '{'{32'sh80000000, 32'sh80000000, 16'sh7FFF, 16'hFFFF, 32'sh7FFFFFFF,
                      32'sh7FFFFFFF, 16'sh7FFF}, 1'b0, 16'h0};
    dir_rows[5]  = '{'{32'sd1000, -32'sd2000, 16'sh7FFF, 16'd300, 32'sd70000, 32'sd4000,
                      16'sh8000}, 1'b0, 16'h0};
    dir_rows[6]  = '{'{32'sd0, 32'sd0, -16'sd1, 16'd512, 32'sd0, 32'sd0, 16'sh8000},
                     1'b0, 16'h0};
    dir_rows[7]  = '{'{32'sd0, 32'sd0, 16'sd0, 16'hFFFF, 32'sd0, 32'sd0, 16'sd0},
                     1'b0, 16'h0};
    dir_rows[8]  = '{'{32'sd0, 32'sd0, 16'sd0, 16'd0, 32'sd65536, 32'sd0, 16'sd0},
                     1'b0, 16'h0};
    dir_rows[9]  = '{'{32'sd0, 32'sd0, 16'sd0, 16'd0, -32'sd65536, 32'sd0, 16'sd0},
                     1'b0, 16'h0};
    dir_rows[10] = '{'{32'sd0, 32'sd0, 16'sh2000, 16'd0, 32'sd0, 32'sd65536, 16'sd0},
                     1'b0, 16'h0};
    dir_rows[11] = '{'{32'sd0, 32'sd0, -16'sh2000, 16'd0, 32'sd0, -32'sd65536, 16'sd0},
                     1'b0, 16'h0};
    dir_rows[12] = '{'{-32'sd1, -32'sd1, -16'sd1, 16'hFFFF, -32'sd1, -32'sd1, -16'sd1},
                     1'b0, 16'h0};
    dir_rows[13] = '{'{32'sh55555555, 32'shAAAAAAAA, 16'sh5555, 16'hAAAA, 32'shAAAAAAAA,
                      32'sh55555555, 16'shAAAA}, 1'b0, 16'h0};

    wb_set   = '{WHEELBASE_RST, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0};
    gain_set = '{SPEED_GAIN_RST, 16'd1, 16'hFFFF, 16'd0, 16'd0};
    wb_set[4]   = 16'($urandom);
    gain_set[4] = 16'($urandom_range(1, 16'hFFFF));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // wheelbase zero puts the front axle on the rear axle
    write_reg(REG_WHEELBASE, 16'd0);
    foreach (dir_rows[i]) send_pose(dir_rows[i].p, dir_rows[i].typed, dir_rows[i].angle);

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_WHEELBASE, wb_set[ph]);
      write_reg(REG_SPEED_GAIN, gain_set[ph]);
      @(negedge clk_i);
      snd_burst = (ph == 1);
      rcv_burst = (ph == 2);
      hold_req = (ph == 1);
      for (int n = 0; n < PhaseLen; n++) begin
        if (ph == 3) snd_burst = (n % 100) < 30;
        send_pose(random_pose(), 1'b0, 16'h0);
      end
    end

    @(negedge clk_i);
    pose.valid = 1'b0;
    while (angle_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
